>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif

`endif

>>> design/grc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_pkg
// shared types, constants and codes of the grid ray caster
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 640;
  localparam int unsigned SCREEN_HEIGHT_DEF = 480;
  localparam int unsigned MAP_SIZE_DEF      = 32;

  localparam int unsigned MAP_DEPTH = 1024;
  localparam int unsigned MAP_AW    = 10;
  localparam int unsigned CELL_W    = 8;

  localparam int unsigned DIV_NW  = 30;  // dividend and quotient width
  localparam int unsigned DIV_DW  = 17;  // divisor width
  localparam int unsigned RAY_W   = 18;  // signed ray component, Q4.14
  localparam int unsigned DELTA_W = 29;
  localparam int unsigned SIDE_W  = 46;
  localparam int unsigned COORD_W = 7;   // map coordinate, negative values wrap to large unsigned ones

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 72;

  typedef enum logic [2:0] {
    REG_POS_X   = 3'd0,
    REG_POS_Y   = 3'd1,
    REG_DIR_X   = 3'd2,
    REG_DIR_Y   = 3'd3,
    REG_PLANE_X = 3'd4,
    REG_PLANE_Y = 3'd5
  } cfg_reg_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_CAM,
    OP_RAY,
    OP_INIT,
    OP_DIV_DX,
    OP_DX,
    OP_DIV_DY,
    OP_DY,
    OP_SIDE,
    OP_STEP,
    OP_TEST,
    OP_DIV_PERP,
    OP_PERP,
    OP_DIV_LH,
    OP_LH,
    OP_RESULT,
    OP_ESCAPE
  } dp_op_e;

  typedef struct packed {
    dp_op_e            op;
    logic [MAP_AW-1:0] clr_addr;
  } cmd_t;

  typedef struct packed {
    logic in_cast;
    logic div_busy;
    logic div_done;
    logic start_out;
    logic oob;
    logic wall_hit;
  } status_t;

endpackage

>>> design/grc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module grc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/grc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module grc_div #(
  parameter int unsigned NW = 30,
  parameter int unsigned DW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [NW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(NW);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DW-1:0]   div_q, rem_q;
  logic [NW-1:0]   quo_q;
  logic [DW:0]     rem_sh;
  logic [DW+1:0]   diff;
  logic            ge;

  assign rem_sh = {rem_q, quo_q[NW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, div_q};
  assign ge     = !diff[DW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> design/grc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_datapath
// camera registers, map store, ray setup, dda walk and result registers
// ----------------------------------------------------------------------------
module grc_datapath #(
  parameter int unsigned SCREEN_WIDTH  = grc_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = grc_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned MAP_SIZE      = grc_pkg::MAP_SIZE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [2:0]                      cfg_index_i,
  input  logic [15:0]                     cfg_data_i,
  input  logic [grc_pkg::IN_DATA_W-1:0]   in_tdata_i,
  input  logic                            in_tuser_i,
  input  grc_pkg::cmd_t                   cmd_i,
  output grc_pkg::status_t                status_o,
  output logic [grc_pkg::OUT_DATA_W-1:0]  out_tdata_o,
  output logic                            out_tuser_o
);

  localparam int unsigned NW = grc_pkg::DIV_NW;
  localparam int unsigned DW = grc_pkg::DIV_DW;
  localparam int unsigned RW = grc_pkg::RAY_W;
  localparam int unsigned CW = grc_pkg::COORD_W;
  localparam int unsigned SW = grc_pkg::SIDE_W;
  localparam int unsigned XW = grc_pkg::DELTA_W;

  // camera x by reciprocal: floor(col * 2^15 / width) = (col * ceil(2^36 / width)) >> 21
  localparam longint unsigned CamRecipL =
    ((64'd1 << 36) + longint'(SCREEN_WIDTH) - 64'd1) / longint'(SCREEN_WIDTH);
  localparam logic [35:0] CamRecip = 36'(CamRecipL);

  // config registers
  logic [14:0]        pos_x_q, pos_y_q;
  logic signed [15:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      dir_x_q   <= 16'sd16384;
      dir_y_q   <= '0;
      plane_x_q <= '0;
      plane_y_q <= 16'sd10813;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        grc_pkg::REG_POS_X:   pos_x_q   <= cfg_data_i[14:0];
        grc_pkg::REG_POS_Y:   pos_y_q   <= cfg_data_i[14:0];
        grc_pkg::REG_DIR_X:   dir_x_q   <= cfg_data_i;
        grc_pkg::REG_DIR_Y:   dir_y_q   <= cfg_data_i;
        grc_pkg::REG_PLANE_X: plane_x_q <= cfg_data_i;
        grc_pkg::REG_PLANE_Y: plane_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input word fields
  logic [9:0] in_column;
  logic [4:0] in_cell_x, in_cell_y;
  logic [7:0] in_cell_value;

  assign in_column     = in_tdata_i[9:0];
  assign in_cell_x     = in_tdata_i[14:10];
  assign in_cell_y     = in_tdata_i[19:15];
  assign in_cell_value = in_tdata_i[27:20];

  // working registers
  logic [9:0]              col_q;
  logic signed [15:0]      cam_q;
  logic signed [RW-1:0]    rx_q, ry_q;
  logic [XW-1:0]           dx_q, dy_q;
  logic [SW-1:0]           side_x_q, side_y_q;
  logic                    inf_x_q, inf_y_q;
  logic [CW-1:0]           mx_q, my_q;
  logic                    side_q;
  logic [7:0]              wall_q;
  logic [15:0]             perp_q;
  logic [11:0]             lh_q;
  logic [grc_pkg::OUT_DATA_W-1:0] out_tdata_q;
  logic                    out_tuser_q;

  // map store
  logic                          ram_we;
  logic [grc_pkg::MAP_AW-1:0]    ram_waddr, ram_raddr;
  logic [grc_pkg::CELL_W-1:0]    ram_wdata, ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {in_cell_y, in_cell_x};
    ram_wdata = in_cell_value;
    if (cmd_i.op == grc_pkg::OP_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = cmd_i.clr_addr;
      ram_wdata = '0;
    end else if (cmd_i.op == grc_pkg::OP_LOAD && !in_tuser_i) begin
      ram_we = 1'b1;
    end
  end

  assign ram_raddr = {my_q[4:0], mx_q[4:0]};

  grc_ram #(
    .WIDTH(grc_pkg::CELL_W),
    .DEPTH(grc_pkg::MAP_DEPTH)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // ray magnitudes
  logic          rx_neg, ry_neg, rx_zero, ry_zero;
  logic [RW-2:0] rx_mag, ry_mag;
  logic [RW-1:0] rx_neg_val, ry_neg_val;

  assign rx_neg     = rx_q[RW-1];
  assign ry_neg     = ry_q[RW-1];
  assign rx_zero    = (rx_q == '0);
  assign ry_zero    = (ry_q == '0);
  assign rx_neg_val = -rx_q;
  assign ry_neg_val = -ry_q;
  assign rx_mag     = rx_neg ? rx_neg_val[RW-2:0] : rx_q[RW-2:0];
  assign ry_mag     = ry_neg ? ry_neg_val[RW-2:0] : ry_q[RW-2:0];

  // distance numerator at the hit boundary
  logic signed [RW-1:0] num;
  logic [RW-1:0]        num_neg_val;
  logic [15:0]          num_mag;
  logic [DW-1:0]        den;
  logic                 den_zero;

  always_comb begin
    if (!side_q) begin
      num = $signed({3'b000, mx_q[4:0], 10'b0}) - $signed({3'b000, pos_x_q})
          + (rx_neg ? RW'(1024) : RW'(0));
      den = rx_mag;
    end else begin
      num = $signed({3'b000, my_q[4:0], 10'b0}) - $signed({3'b000, pos_y_q})
          + (ry_neg ? RW'(1024) : RW'(0));
      den = ry_mag;
    end
  end

  assign num_neg_val = -num;
  assign num_mag     = num[RW-1] ? num_neg_val[15:0] : num[15:0];
  assign den_zero    = (den == '0);

  // shared divider
  logic          div_start, div_busy, div_done;
  logic [NW-1:0] div_num, div_q;
  logic [DW-1:0] div_den;

  always_comb begin
    div_start = 1'b1;
    div_num   = NW'(1) << 28;
    div_den   = rx_mag;
    case (cmd_i.op)
      grc_pkg::OP_DIV_DX: div_den = rx_mag;
      grc_pkg::OP_DIV_DY: div_den = ry_mag;
      grc_pkg::OP_DIV_PERP: begin
        div_num = {num_mag, 14'b0};
        div_den = den;
      end
      grc_pkg::OP_DIV_LH: begin
        div_num = NW'(SCREEN_HEIGHT) << 10;
        div_den = DW'(perp_q);
      end
      default: div_start = 1'b0;
    endcase
  end

  grc_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_num),
    .divisor_i (div_den),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quotient_o(div_q)
  );

  // camera x product
  logic [45:0] cam_prod;
  assign cam_prod = {36'b0, col_q} * {10'b0, CamRecip};

  // ray products
  logic signed [31:0] prod_x, prod_y, shr_x, shr_y;

  assign prod_x = plane_x_q * cam_q;
  assign prod_y = plane_y_q * cam_q;
  assign shr_x  = prod_x >>> 14;
  assign shr_y  = prod_y >>> 14;

  // initial side distances
  logic [9:0]  fx, fy;
  logic [10:0] dist_x, dist_y;
  logic [39:0] side_x_init, side_y_init;

  assign fx          = pos_x_q[9:0];
  assign fy          = pos_y_q[9:0];
  assign dist_x      = rx_neg ? {1'b0, fx} : 11'd1024 - {1'b0, fx};
  assign dist_y      = ry_neg ? {1'b0, fy} : 11'd1024 - {1'b0, fy};
  assign side_x_init = dist_x * dx_q;
  assign side_y_init = dist_y * dy_q;

  logic x_step;
  assign x_step = !inf_x_q && (inf_y_q || side_x_q < side_y_q);

  // draw span
  logic [10:0]       half_lh;
  logic signed [12:0] ds_s;
  logic [12:0]       de_s;
  logic [9:0]        ds, de;

  assign half_lh = lh_q[11:1];
  assign ds_s    = $signed(13'(SCREEN_HEIGHT / 2)) - $signed({2'b00, half_lh});
  assign de_s    = 13'(SCREEN_HEIGHT / 2) + {2'b00, half_lh};
  assign ds      = ds_s[12] ? 10'd0 : ds_s[9:0];
  assign de      = (de_s >= 13'(SCREEN_HEIGHT)) ? 10'(SCREEN_HEIGHT - 1) : de_s[9:0];

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      grc_pkg::OP_LOAD: begin
        col_q <= (in_column > 10'(SCREEN_WIDTH - 1)) ? 10'(SCREEN_WIDTH - 1) : in_column;
      end
      grc_pkg::OP_CAM: cam_q <= $signed(cam_prod[36:21] - 16'd16384);
      grc_pkg::OP_RAY: begin
        rx_q <= RW'(dir_x_q) + RW'(shr_x);
        ry_q <= RW'(dir_y_q) + RW'(shr_y);
      end
      grc_pkg::OP_INIT: begin
        mx_q <= CW'(pos_x_q[14:10]);
        my_q <= CW'(pos_y_q[14:10]);
      end
      grc_pkg::OP_DX: dx_q <= div_q[XW-1:0];
      grc_pkg::OP_DY: dy_q <= div_q[XW-1:0];
      grc_pkg::OP_SIDE: begin
        side_x_q <= SW'(side_x_init);
        side_y_q <= SW'(side_y_init);
        inf_x_q  <= rx_zero;
        inf_y_q  <= ry_zero;
      end
      grc_pkg::OP_STEP: begin
        if (x_step) begin
          side_x_q <= side_x_q + SW'({dx_q, 10'b0});
          mx_q     <= rx_neg ? mx_q - 1'b1 : mx_q + 1'b1;
          side_q   <= 1'b0;
        end else begin
          if (!inf_y_q) begin
            side_y_q <= side_y_q + SW'({dy_q, 10'b0});
          end
          my_q   <= ry_neg ? my_q - 1'b1 : my_q + 1'b1;
          side_q <= 1'b1;
        end
      end
      grc_pkg::OP_TEST: wall_q <= ram_rdata;
      grc_pkg::OP_PERP: begin
        perp_q <= (den_zero || div_q > NW'(16'hFFFF)) ? 16'hFFFF : div_q[15:0];
      end
      grc_pkg::OP_LH: begin
        lh_q <= (perp_q == '0 || div_q > NW'(12'hFFF)) ? 12'hFFF : div_q[11:0];
      end
      grc_pkg::OP_RESULT: begin
        out_tdata_q <= {5'b0, de, ds, lh_q, perp_q, wall_q, my_q[4:0], mx_q[4:0], side_q};
        out_tuser_q <= 1'b0;
      end
      grc_pkg::OP_ESCAPE: begin
        out_tdata_q <= '0;
        out_tuser_q <= 1'b1;
      end
      default: ;
    endcase
  end

  // negative coordinates wrap to large unsigned values
  assign status_o.in_cast   = in_tuser_i;
  assign status_o.div_busy  = div_busy;
  assign status_o.div_done  = div_done;
  assign status_o.start_out = (pos_x_q[14:10] >= 5'(MAP_SIZE - 1) + 5'd1) && (MAP_SIZE < 32)
                            || (pos_y_q[14:10] >= 5'(MAP_SIZE - 1) + 5'd1) && (MAP_SIZE < 32);
  assign status_o.oob       = (mx_q >= CW'(MAP_SIZE)) || (my_q >= CW'(MAP_SIZE));
  assign status_o.wall_hit  = (ram_rdata != '0);

  assign out_tdata_o = out_tdata_q;
  assign out_tuser_o = out_tuser_q;

endmodule

>>> design/grc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_ctrl
// sequencer for map clearing, map writes and the ray cast of one column
// ----------------------------------------------------------------------------
module grc_ctrl #(
  parameter int unsigned MAP_SIZE = grc_pkg::MAP_SIZE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  grc_pkg::status_t status_i,
  output grc_pkg::cmd_t    cmd_o
);

  localparam int unsigned StepLimit = 2 * MAP_SIZE + 2;
  localparam int unsigned StepW     = $clog2(StepLimit + 1);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CAM, S_RAY, S_INIT, S_DX_DIV, S_DX_WAIT,
    S_DY_DIV, S_DY_WAIT, S_SIDE, S_STEP, S_CHECK, S_TEST, S_PERP_DIV,
    S_PERP_WAIT, S_LH_DIV, S_LH_WAIT, S_RESULT, S_ESCAPE
  } state_e;

  state_e                     state_q, state_d;
  logic [grc_pkg::MAP_AW-1:0] clr_q;
  logic [StepW-1:0]           steps_q;
  logic                       out_valid_q;
  logic                       out_free, in_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_ready_o && in_valid_i;

  always_comb begin
    state_d       = state_q;
    cmd_o.op       = grc_pkg::OP_NONE;
    cmd_o.clr_addr = clr_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = grc_pkg::OP_CLEAR;
        if (clr_q == grc_pkg::MAP_AW'(grc_pkg::MAP_DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd_o.op = grc_pkg::OP_LOAD;
          if (status_i.in_cast) state_d = S_CAM;
        end
      end
      S_CAM: begin
        cmd_o.op = grc_pkg::OP_CAM;
        state_d  = S_RAY;
      end
      S_RAY: begin
        cmd_o.op = grc_pkg::OP_RAY;
        state_d  = S_INIT;
      end
      S_INIT: begin
        cmd_o.op = grc_pkg::OP_INIT;
        state_d  = status_i.start_out ? S_ESCAPE : S_DX_DIV;
      end
      S_DX_DIV: begin
        cmd_o.op = grc_pkg::OP_DIV_DX;
        state_d  = S_DX_WAIT;
      end
      S_DX_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.op = grc_pkg::OP_DX;
          state_d  = S_DY_DIV;
        end
      end
      S_DY_DIV: begin
        cmd_o.op = grc_pkg::OP_DIV_DY;
        state_d  = S_DY_WAIT;
      end
      S_DY_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.op = grc_pkg::OP_DY;
          state_d  = S_SIDE;
        end
      end
      S_SIDE: begin
        cmd_o.op = grc_pkg::OP_SIDE;
        state_d  = S_STEP;
      end
      S_STEP: begin
        cmd_o.op = grc_pkg::OP_STEP;
        state_d  = S_CHECK;
      end
      // map read address settles here, data is there in the next cycle
      S_CHECK: state_d = status_i.oob ? S_ESCAPE : S_TEST;
      S_TEST: begin
        cmd_o.op = grc_pkg::OP_TEST;
        if (status_i.wall_hit) state_d = S_PERP_DIV;
        else if (steps_q == StepW'(StepLimit)) state_d = S_ESCAPE;
        else state_d = S_STEP;
      end
      S_PERP_DIV: begin
        cmd_o.op = grc_pkg::OP_DIV_PERP;
        state_d  = S_PERP_WAIT;
      end
      S_PERP_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.op = grc_pkg::OP_PERP;
          state_d  = S_LH_DIV;
        end
      end
      S_LH_DIV: begin
        cmd_o.op = grc_pkg::OP_DIV_LH;
        state_d  = S_LH_WAIT;
      end
      S_LH_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.op = grc_pkg::OP_LH;
          state_d  = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          cmd_o.op = grc_pkg::OP_RESULT;
          state_d  = S_IDLE;
        end
      end
      S_ESCAPE: begin
        if (out_free) begin
          cmd_o.op = grc_pkg::OP_ESCAPE;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == S_SIDE) steps_q <= '0;
      else if (state_q == S_STEP) steps_q <= steps_q + 1'b1;
      if ((state_q == S_RESULT || state_q == S_ESCAPE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> design/grid_ray_caster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_ray_caster
// dda grid ray caster for one screen column, fixed point
// ----------------------------------------------------------------------------
// A cast word walks at most 2*MAP_SIZE+2 grid steps: camera x comes from a
// constant reciprocal multiply, and four divisions (both ray deltas, wall
// distance, line height) share one restoring divider at one quotient bit a
// cycle, and every step of the walk is a side update, a map read and a wall
// test. One cast is in work at a time; the next word is taken while a
// finished result waits in the output register. After reset the map store is
// swept to zero, and no word is taken meanwhile; configuration writes are
// taken at any time.
module grid_ray_caster #(
  parameter int unsigned SCREEN_WIDTH  = grc_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = grc_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned MAP_SIZE      = grc_pkg::MAP_SIZE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [2:0]                     cfg_index_i,
  input  logic [15:0]                    cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // column, cell_x, cell_y, cell_value, zero pad
  input  logic [grc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // hit_side, hit_x, hit_y, wall_value, perp_dist, line_height,
  // draw_start, draw_end, zero pad
  output logic [grc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // escaped
  output logic                           m_axis_tuser
);

  `include "assert_macros.svh"

  grc_pkg::cmd_t    cmd;
  grc_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  grc_ctrl #(
    .MAP_SIZE(MAP_SIZE)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  grc_datapath #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .MAP_SIZE     (MAP_SIZE)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_tdata_i (s_axis_tdata),
    .in_tuser_i (s_axis_tuser),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_tdata_o(m_axis_tdata),
    .out_tuser_o(m_axis_tuser)
  );

  `ASSERT_NEVER(a_ready_while_div, s_axis_tready && status.div_busy, "input ready during division")
  `ASSERT_CLK(a_escape_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0, "escape word not zero")
  `ASSERT_CLK(a_span_order, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[56:47] <= m_axis_tdata[66:57], "draw span reversed")

endmodule
